// ----- design/ssd_pkg.sv -----
// Shared constants and types for the step segment detector.
`timescale 1ns / 1ps
`default_nettype none
package ssd_pkg;

  localparam int INDEX_BITS = 24;
  localparam int COUNT_BITS = 16;
  localparam int MINLEN_BITS = 16;
  // Width for comparing segment lengths against the minimum.
  localparam int CMP_BITS = (INDEX_BITS > MINLEN_BITS) ? INDEX_BITS : MINLEN_BITS;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;

  typedef struct packed {
    logic step_found;
    idx_t step_begin;
    idx_t step_end;
    cnt_t step_total;
  } res_t;

endpackage
`default_nettype wire

// ----- design/step_segment_detector_core.sv -----
// Top level of the step segment detector: segmenter state, output register and skid stage.
`timescale 1ns / 1ps
`default_nettype none
// Usage
// - Input channel (in_valid / in_stall): one beat per sample with the activity
//   flag in_active and the record-start mark in_record_start.
// - Result channel (out_valid / out_stall): exactly one beat per input beat,
//   in order: step_found, step_begin, step_end and the running step_total.
// - Configuration channel (cfg_valid / cfg_ready): one beat writes
//   min_segment_length; cfg_ready is always high. Write only while idle.
// - Each result is registered in the output register, or in the skid if that is held.
// - Throughput: one sample per cycle unless in_stall; the segmenter is a single
//   compare and subtract stage between the input handshake and the output register.
// - Stall: a result that cannot leave drops into a one-entry skid stage, so
//   one more input beat is taken; in_stall rises only while the skid is full.
// - Reset (rst_n low, synchronous): index, phase, marks and step count clear,
//   min_segment_length returns to 1, both output stages empty.
module step_segment_detector_core
  import ssd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_active,
  input  wire logic                   in_record_start,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_step_found,
  output logic [INDEX_BITS-1:0]       out_step_begin,
  output logic [INDEX_BITS-1:0]       out_step_end,
  output logic [COUNT_BITS-1:0]       out_step_total,
  // configuration channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [MINLEN_BITS-1:0] cfg_min_segment_length
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_UNUSED = 2'd3;

  // Segmenter state
  logic [MINLEN_BITS-1:0] min_len_r;
  idx_t                   index_r, index_nxt;
  logic                   prev_flag_r, prev_flag_nxt;
  logic [1:0]             phase_r, phase_nxt;
  idx_t                   open_start_r, open_start_nxt;
  idx_t                   first_mark_r, first_mark_nxt;
  idx_t                   second_mark_r, second_mark_nxt;
  idx_t                   last_stop_r, last_stop_nxt;
  cnt_t                   step_cnt_r, step_cnt_nxt;

  // Output register and skid stage
  logic out_valid_r, skid_valid_r;
  res_t out_res_r, skid_res_r;
  res_t res_nxt;

  logic in_take, out_take;
  idx_t idx_inc, len2;
  logic long_enough;

  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  assign idx_inc = index_r + idx_t'(1);
  assign len2    = idx_inc - second_mark_r;
  assign long_enough = (CMP_BITS'(first_mark_r) >= CMP_BITS'(min_len_r)) &&
                       (CMP_BITS'(len2) >= CMP_BITS'(min_len_r));

  // One sample through the segmenter
  always_comb begin
    index_nxt       = index_r;
    prev_flag_nxt   = prev_flag_r;
    phase_nxt       = phase_r;
    open_start_nxt  = open_start_r;
    first_mark_nxt  = first_mark_r;
    second_mark_nxt = second_mark_r;
    last_stop_nxt   = last_stop_r;
    step_cnt_nxt    = step_cnt_r;
    res_nxt         = '0;
    if (in_record_start) begin
      // restart the record; the step count is kept
      index_nxt     = '0;
      phase_nxt     = PH_IDLE;
      prev_flag_nxt = in_active;
    end else begin
      index_nxt     = idx_inc;
      prev_flag_nxt = in_active;
      if (in_active != prev_flag_r) begin
        case (phase_r)
          PH_FIRST: begin
            // first segment ends: keep its length, mark the second change
            first_mark_nxt  = idx_inc - first_mark_r;
            second_mark_nxt = idx_inc;
            phase_nxt       = PH_SECOND;
          end
          PH_SECOND: begin
            // close the step one sample back, then reopen at this change
            last_stop_nxt = idx_inc - idx_t'(1);
            if (long_enough) begin
              if (step_cnt_r != '1) begin
                step_cnt_nxt = step_cnt_r + cnt_t'(1);
              end
              res_nxt.step_found = 1'b1;
              res_nxt.step_begin = open_start_r;
              res_nxt.step_end   = idx_inc - idx_t'(1);
            end
            open_start_nxt = idx_inc;
            first_mark_nxt = idx_inc;
            phase_nxt      = PH_FIRST;
          end
          default: begin
            // idle (and the unused code): open a step
            open_start_nxt = idx_inc;
            first_mark_nxt = idx_inc;
            phase_nxt      = PH_FIRST;
          end
        endcase
      end
    end
    res_nxt.step_total = step_cnt_nxt;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MINLEN_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      min_len_r <= cfg_min_segment_length;
    end
  end

  // Advance the segmenter on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r       <= '0;
      prev_flag_r   <= 1'b0;
      phase_r       <= PH_IDLE;
      open_start_r  <= '0;
      first_mark_r  <= '0;
      second_mark_r <= '0;
      last_stop_r   <= '0;
      step_cnt_r    <= '0;
    end else if (in_take) begin
      index_r       <= index_nxt;
      prev_flag_r   <= prev_flag_nxt;
      phase_r       <= phase_nxt;
      open_start_r  <= open_start_nxt;
      first_mark_r  <= first_mark_nxt;
      second_mark_r <= second_mark_nxt;
      last_stop_r   <= last_stop_nxt;
      step_cnt_r    <= step_cnt_nxt;
    end
  end

  // Output register with skid: the skid drains first, new results fill the
  // output register when it frees up, else park in the skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_take) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_res_r <= skid_res_r;
      end
    end else if (in_take) begin
      if (!out_valid_r || out_take) begin
        out_res_r <= res_nxt;
      end else begin
        skid_res_r <= res_nxt;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step_found = out_res_r.step_found;
  assign out_step_begin = out_res_r.step_begin;
  assign out_step_end   = out_res_r.step_end;
  assign out_step_total = out_res_r.step_total;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_UNUSED)
    else $error("segmenter reached the unused phase");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 step_cnt_r >= $past(step_cnt_r))
    else $error("step count went down");

  a_found_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.step_found) |-> (out_res_r.step_total != '0))
    else $error("step reported with a zero step total");

endmodule
`default_nettype wire
